// ----- design/bbpp_pkg.sv -----
package bbpp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;

  localparam int unsigned RATE_W    = 32;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned RT_W      = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned EL_W      = 16;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned BUDGET_W  = 48;
  localparam int unsigned QTOT_W    = 32;
  localparam int unsigned GAIN_W    = 3;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = RATE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PHASE = 1'b1;

  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // credit = gain_quarters * rate * ms / (4 * 1000 ms * 8 bits)
  localparam int unsigned CREDIT_DENOM = 4 * 1000 * 8;
  localparam int unsigned CREDIT_SHIFT = 8;
  localparam int unsigned CREDIT_DIV   = CREDIT_DENOM >> CREDIT_SHIFT;

  // divide by CREDIT_DIV as a multiply by its rounded-up reciprocal
  localparam int unsigned CREDIT_DIV_W   = $clog2(CREDIT_DIV);
  localparam int unsigned CREDIT_X_W     = BYTES_W + CREDIT_DIV_W;
  localparam int unsigned CREDIT_RSHIFT  = CREDIT_X_W + CREDIT_DIV_W;
  localparam int unsigned CREDIT_RECIP_W = CREDIT_RSHIFT - CREDIT_DIV_W + 1;
  localparam logic [CREDIT_RECIP_W-1:0] CREDIT_RECIP = CREDIT_RECIP_W'(
    ((64'd1 << CREDIT_RSHIFT) + 64'(CREDIT_DIV) - 64'd1) / 64'(CREDIT_DIV));

  typedef enum logic [1:0] {
    KIND_SENT  = 2'd0,
    KIND_PROBE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_DROP  = 2'd3
  } kind_e;

  typedef struct packed {
    logic                   opcode;
    logic [ID_W-1:0]        pkt_id;
    logic signed [RT_W-1:0] retrans_mark;
    logic [LEN_W-1:0]       packet_length;
    logic [EL_W-1:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    kind_e                      kind;
    logic [ID_W-1:0]            sent_id;
    logic signed [RT_W-1:0]     sent_retrans;
    logic [SEQ_W-1:0]           transmit_seq;
    logic [BYTES_W-1:0]         byte_count;
    logic signed [BUDGET_W-1:0] budget_now;
    logic [QTOT_W-1:0]          queued_total;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [RT_W-1:0]  rt;
    logic [LEN_W-1:0] len;
  } fifo_entry_t;

  function automatic logic [GAIN_W-1:0] gain_quarters(input logic [PHASE_W-1:0] phase);
    logic [GAIN_W-1:0] g;
    case (phase)
      3'd0:    g = 3'd5;
      3'd1:    g = 3'd3;
      default: g = 3'd4;
    endcase
    return g;
  endfunction

endpackage

// ----- design/bbpp_chan_if.sv -----
interface bbpp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/byte_budget_packet_pacer.sv -----
// Enqueue: an accepted beat is written to the queue and gives no result; a full queue
// loads a drop result from the drop state once the output is free, and the next beat is taken after that.
// Tick with nothing to send: credit (32x16 multiply, gain scale, two-step reciprocal
// multiply) and budget, a queue check, tick done, idle; each sent packet adds a send state
// and another queue check (registered queue memory read), a probe a state; output stalls add more.
// Reset is asynchronous, active low, clears control and budget state; queue memory stays.
module byte_budget_packet_pacer #(
  parameter int unsigned QUEUE_DEPTH = bbpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bbpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bbpp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  bbpp_chan_if.sink                        in_i,
  bbpp_chan_if.source                      out_o
);
  import bbpp_pkg::*;

  localparam int unsigned IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = IDX_W + 1;
  localparam int unsigned ENTRY_W = $bits(fifo_entry_t);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DROP   = 3'd1;
  localparam logic [2:0] ST_CREDIT = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_SEND   = 3'd4;
  localparam logic [2:0] ST_PROBE  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [RATE_W-1:0]          rate_q, rate_d;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic [IDX_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic signed [BUDGET_W-1:0] budget_q, budget_d;
  logic [QTOT_W-1:0]          queued_q, queued_d;
  logic [SEQ_W-1:0]           seq_q, seq_d;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;
  in_item_t                   item_q;
  logic [BYTES_W-1:0]         credit_q, credit_d;

  logic [ENTRY_W-1:0]         mem_q [QUEUE_DEPTH];
  fifo_entry_t                rd_data_q;
  logic                       mem_we, mem_re;
  fifo_entry_t                wr_entry;

  logic                       in_acc, out_free, full, load;
  logic [SUM_W-1:0]           tail_sum;
  logic [IDX_W-1:0]           tail;
  logic [QTOT_W:0]            queued_sum;
  logic                       cr_start, cr_done;
  logic [BYTES_W-1:0]         cr_credit;
  logic signed [BUDGET_W-1:0] budget_sent;
  logic [QTOT_W-1:0]          queued_sent;

  bbpp_credit u_credit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cr_start),
    .elapsed_i (in_i.data.elapsed_ms),
    .rate_i    (rate_q),
    .phase_i   (phase_q),
    .done_o    (cr_done),
    .credit_o  (cr_credit)
  );

  assign in_i.ready  = state_q == ST_IDLE;
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_free    = !out_valid_q | out_o.ready;
  assign full        = count_q == CNT_W'(QUEUE_DEPTH);
  assign tail_sum    = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail        = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                       ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
  assign queued_sum  = (QTOT_W+1)'(queued_q) + (QTOT_W+1)'(in_i.data.packet_length);
  assign budget_sent = budget_q - $signed(BUDGET_W'(rd_data_q.len));
  assign queued_sent = (queued_q >= QTOT_W'(rd_data_q.len))
                       ? queued_q - QTOT_W'(rd_data_q.len) : '0;

  assign wr_entry.id  = in_i.data.pkt_id;
  assign wr_entry.rt  = in_i.data.retrans_mark;
  assign wr_entry.len = in_i.data.packet_length;

  always_comb begin
    state_d  = state_q;
    rate_d   = rate_q;
    phase_d  = phase_q;
    head_d   = head_q;
    count_d  = count_q;
    budget_d = budget_q;
    queued_d = queued_q;
    seq_d    = seq_q;
    credit_d = credit_q;
    out_d    = out_q;
    load     = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    cr_start = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_RATE:   rate_d  = cfg_wdata_i;
        CFG_GAIN_PHASE: phase_d = cfg_wdata_i[PHASE_W-1:0];
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.opcode == OP_ENQ) begin
            if (full) begin
              state_d = ST_DROP;
            end else begin
              mem_we   = 1'b1;
              count_d  = count_q + 1'b1;
              queued_d = queued_sum[QTOT_W] ? '1 : queued_sum[QTOT_W-1:0];
            end
          end else begin
            cr_start = 1'b1;
            state_d  = ST_CREDIT;
          end
        end
      end
      ST_DROP: begin
        if (out_free) begin
          load               = 1'b1;
          out_d.kind         = KIND_DROP;
          out_d.sent_id      = item_q.pkt_id;
          out_d.sent_retrans = item_q.retrans_mark;
          out_d.transmit_seq = '0;
          out_d.byte_count   = BYTES_W'(item_q.packet_length);
          out_d.budget_now   = budget_q;
          out_d.queued_total = queued_q;
          out_d.last         = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_CREDIT: begin
        if (cr_done) begin
          credit_d = cr_credit;
          if (budget_q[BUDGET_W-1]) begin
            budget_d = budget_q + $signed(BUDGET_W'(cr_credit));
          end else begin
            budget_d = $signed(BUDGET_W'(cr_credit));
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (count_q != '0 && !budget_q[BUDGET_W-1]) begin
          mem_re  = 1'b1;
          state_d = ST_SEND;
        end else if (count_q == '0 && !budget_q[BUDGET_W-1] && budget_q != '0
                     && phase_q == '0) begin
          state_d = ST_PROBE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          load               = 1'b1;
          head_d             = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d            = count_q - 1'b1;
          budget_d           = budget_sent;
          queued_d           = queued_sent;
          seq_d              = seq_q + 1'b1;
          out_d.kind         = KIND_SENT;
          out_d.sent_id      = rd_data_q.id;
          out_d.sent_retrans = rd_data_q.rt;
          out_d.transmit_seq = seq_q;
          out_d.byte_count   = BYTES_W'(rd_data_q.len);
          out_d.budget_now   = budget_sent;
          out_d.queued_total = queued_sent;
          out_d.last         = 1'b0;
          state_d            = ST_CHECK;
        end
      end
      ST_PROBE: begin
        if (out_free) begin
          load               = 1'b1;
          budget_d           = '0;
          out_d.kind         = KIND_PROBE;
          out_d.sent_id      = '0;
          out_d.sent_retrans = '0;
          out_d.transmit_seq = '0;
          out_d.byte_count   = (budget_q[BUDGET_W-1:BYTES_W] != '0)
                               ? '1 : budget_q[BYTES_W-1:0];
          out_d.budget_now   = '0;
          out_d.queued_total = queued_q;
          out_d.last         = 1'b0;
          state_d            = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load               = 1'b1;
          out_d.kind         = KIND_TICK;
          out_d.sent_id      = '0;
          out_d.sent_retrans = '0;
          out_d.transmit_seq = '0;
          out_d.byte_count   = credit_q;
          out_d.budget_now   = budget_q;
          out_d.queued_total = queued_q;
          out_d.last         = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = load | (out_valid_q & !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= '0;
      phase_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      budget_q    <= '0;
      queued_q    <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rate_q      <= rate_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      count_q     <= count_d;
      budget_q    <= budget_d;
      queued_q    <= queued_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    credit_q <= credit_d;
    if (in_acc) begin
      item_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail] <= wr_entry;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ----- design/bbpp_credit.sv -----
module bbpp_credit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bbpp_pkg::EL_W-1:0]     elapsed_i,
  input  logic [bbpp_pkg::RATE_W-1:0]   rate_i,
  input  logic [bbpp_pkg::PHASE_W-1:0]  phase_i,
  output logic                          done_o,
  output logic [bbpp_pkg::BYTES_W-1:0]  credit_o
);
  import bbpp_pkg::*;

  localparam int unsigned PROD_W   = RATE_W + EL_W;
  localparam int unsigned SCALED_W = PROD_W + GAIN_W;
  localparam int unsigned QUO_W    = SCALED_W - CREDIT_SHIFT;
  localparam int unsigned XL_W     = (CREDIT_X_W + 1) / 2;
  localparam int unsigned PART_W   = XL_W + CREDIT_RECIP_W;
  localparam int unsigned ACC_W    = CREDIT_RSHIFT + BYTES_W;

  localparam logic [QUO_W-1:0] SAT_LIM = QUO_W'(64'(CREDIT_DIV) << BYTES_W);

  localparam logic [2:0] CR_IDLE   = 3'd0;
  localparam logic [2:0] CR_GAIN   = 3'd1;
  localparam logic [2:0] CR_MUL_LO = 3'd2;
  localparam logic [2:0] CR_MUL_HI = 3'd3;
  localparam logic [2:0] CR_FIN    = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [CREDIT_X_W-1:0] x_q, x_d;
  logic                  sat_q, sat_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [SCALED_W-1:0]   scaled;
  logic [QUO_W-1:0]      quo;
  logic [XL_W-1:0]       mul_a;
  logic [PART_W-1:0]     part;

  assign scaled = SCALED_W'(prod_q) * SCALED_W'(gain_quarters(phase_i));
  assign quo    = scaled[SCALED_W-1:CREDIT_SHIFT];
  assign mul_a  = (state_q == CR_MUL_HI) ? XL_W'(x_q[CREDIT_X_W-1:XL_W]) : x_q[XL_W-1:0];
  assign part   = PART_W'(mul_a) * PART_W'(CREDIT_RECIP);

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    x_d     = x_q;
    sat_d   = sat_q;
    acc_d   = acc_q;
    unique case (state_q)
      CR_IDLE: begin
        if (start_i) begin
          prod_d  = PROD_W'(rate_i) * PROD_W'(elapsed_i);
          state_d = CR_GAIN;
        end
      end
      CR_GAIN: begin
        sat_d   = quo >= SAT_LIM;
        x_d     = quo[CREDIT_X_W-1:0];
        state_d = CR_MUL_LO;
      end
      CR_MUL_LO: begin
        acc_d   = ACC_W'(part);
        state_d = CR_MUL_HI;
      end
      CR_MUL_HI: begin
        acc_d   = acc_q + (ACC_W'(part) << XL_W);
        state_d = CR_FIN;
      end
      CR_FIN: begin
        state_d = CR_IDLE;
      end
      default: state_d = CR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    x_q    <= x_d;
    sat_q  <= sat_d;
    acc_q  <= acc_d;
  end

  assign done_o   = state_q == CR_FIN;
  assign credit_o = sat_q ? '1 : acc_q[CREDIT_RSHIFT +: BYTES_W];

endmodule

// ----- design/bbpp_checker.sv -----
module bbpp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bbpp_pkg::out_item_t out_data_i
);
  import bbpp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output beat changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.last ==
      (out_data_i.kind == KIND_TICK || out_data_i.kind == KIND_DROP))
    else $error("last flag does not match beat kind");

  a_probe_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_PROBE |->
      out_data_i.budget_now == '0 && out_data_i.sent_id == '0
      && out_data_i.transmit_seq == '0)
    else $error("probe beat must leave zero budget");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid coming out of reset");

endmodule

bind byte_budget_packet_pacer bbpp_checker u_bbpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ----- dv/tb_byte_budget_packet_pacer.sv -----
`timescale 1ns / 1ps

module tb_byte_budget_packet_pacer;
  import bbpp_pkg::*;

  localparam int unsigned QDEPTH    = QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_CAP = 500000;
  localparam int unsigned SETTLE    = 80;
  localparam int unsigned PHASE_LEN = 34;
  localparam longint      BUDGET_HI = 64'sd140737488355327;
  localparam longint      BUDGET_LO = -BUDGET_HI - 64'sd1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bbpp_chan_if #(.T(in_item_t))  in_ch ();
  bbpp_chan_if #(.T(out_item_t)) out_ch ();

  byte_budget_packet_pacer #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // pacer state as the block should hold it
  fifo_entry_t    held_pkts[$];
  longint         budget;
  bit [31:0]      queued_bytes;
  bit [31:0]      tx_seq;
  bit [31:0]      rate_bps;
  bit [2:0]       gain_idx;

  in_item_t       beats_to_send[$];
  out_item_t      pending_results[$];
  int unsigned    pushed, accepted, results_seen, mismatches, idle_pct;
  int unsigned    n_sent, n_probe, n_drop, n_tick, cycles;
  bit             in_fire;

  function automatic longint unsigned gain_of(input bit [2:0] idx);
    case (idx)
      3'd0:    return 64'd5;
      3'd1:    return 64'd3;
      default: return 64'd4;
    endcase
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > BUDGET_HI) return BUDGET_HI;
    if (v < BUDGET_LO) return BUDGET_LO;
    return v;
  endfunction

  task automatic pace_item(input in_item_t it);
    out_item_t         r;
    fifo_entry_t       pk;
    longint unsigned   credit;
    bit [32:0]         sum;
    if (it.opcode == OP_ENQ) begin
      if (held_pkts.size() >= QDEPTH) begin
        r = '0;
        r.kind = KIND_DROP;
        r.sent_id = it.pkt_id;
        r.sent_retrans = it.retrans_mark;
        r.byte_count = 32'(it.packet_length);
        r.budget_now = budget[47:0];
        r.queued_total = queued_bytes;
        r.last = 1'b1;
        pending_results = {pending_results, r};
        n_drop++;
      end else begin
        pk.id = it.pkt_id;
        pk.rt = it.retrans_mark;
        pk.len = it.packet_length;
        held_pkts = {held_pkts, pk};
        sum = {1'b0, queued_bytes} + 33'(it.packet_length);
        queued_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end else begin
      credit = gain_of(gain_idx) * 64'(rate_bps) * 64'(it.elapsed_ms) / 64'd32000;
      if (credit > 64'hFFFF_FFFF) credit = 64'hFFFF_FFFF;
      if (budget < 0) budget = clamp48(budget + longint'(credit));
      else budget = longint'(credit);
      while (held_pkts.size() != 0 && budget >= 0) begin
        pk = held_pkts[0];
        held_pkts.delete(0);
        budget = clamp48(budget - longint'(pk.len));
        queued_bytes = (queued_bytes >= 32'(pk.len)) ? queued_bytes - 32'(pk.len) : 32'd0;
        r = '0;
        r.kind = KIND_SENT;
        r.sent_id = pk.id;
        r.sent_retrans = pk.rt;
        r.transmit_seq = tx_seq;
        r.byte_count = 32'(pk.len);
        r.budget_now = budget[47:0];
        r.queued_total = queued_bytes;
        pending_results = {pending_results, r};
        tx_seq++;
        n_sent++;
      end
      if (held_pkts.size() == 0 && budget > 0 && gain_idx == 3'd0) begin
        r = '0;
        r.kind = KIND_PROBE;
        r.byte_count = (budget > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : budget[31:0];
        budget = 0;
        r.queued_total = queued_bytes;
        pending_results = {pending_results, r};
        n_probe++;
      end
      r = '0;
      r.kind = KIND_TICK;
      r.byte_count = credit[31:0];
      r.budget_now = budget[47:0];
      r.queued_total = queued_bytes;
      r.last = 1'b1;
      pending_results = {pending_results, r};
      n_tick++;
    end
  endtask

  // driver: present beats at the falling edge
  always @(negedge clk_i) begin : drive
    bit take;
    if (rst_ni) begin
      if (!in_ch.valid || in_fire) begin
        take = beats_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct;
        if (take) begin
          in_ch.data <= beats_to_send[0];
          beats_to_send.delete(0);
        end
        in_ch.valid <= take;
      end
      out_ch.ready <= $urandom_range(0, 99) >= idle_pct;
    end
  end

  // monitor: check results, then predict from the accepted beat
  always @(posedge clk_i) begin : watch
    out_item_t got, want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d id=%h bytes=%0d", got.kind, got.sent_id,
                     got.byte_count);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got.kind !== want.kind || got.sent_id !== want.sent_id ||
              got.sent_retrans !== want.sent_retrans || got.transmit_seq !== want.transmit_seq ||
              got.byte_count !== want.byte_count || got.budget_now !== want.budget_now ||
              got.queued_total !== want.queued_total || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("#%0d exp: kind=%0d id=%h rt=%0d seq=%0d bytes=%0d budget=%0d q=%0d last=%b",
                       results_seen, want.kind, want.sent_id, want.sent_retrans, want.transmit_seq,
                       want.byte_count, want.budget_now, want.queued_total, want.last);
              $display("#%0d got: kind=%0d id=%h rt=%0d seq=%0d bytes=%0d budget=%0d q=%0d last=%b",
                       results_seen, got.kind, got.sent_id, got.sent_retrans, got.transmit_seq,
                       got.byte_count, got.budget_now, got.queued_total, got.last);
            end
          end
        end
      end
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        accepted++;
        pace_item(in_ch.data);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_beat(input logic op, input logic [31:0] id, input logic [7:0] rt,
                          input logic [15:0] len, input logic [15:0] el);
    in_item_t it;
    it.opcode = op;
    it.pkt_id = id;
    it.retrans_mark = rt;
    it.packet_length = len;
    it.elapsed_ms = el;
    beats_to_send = {beats_to_send, it};
    pushed++;
  endtask

  task automatic add_packet();
    int unsigned roll;
    logic [15:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 70) len = 16'($urandom_range(40, 1500));
    else if (roll < 90) len = 16'($urandom_range(0, 65535));
    else if (roll < 95) len = 16'd0;
    else len = 16'hFFFF;
    add_beat(OP_ENQ, $urandom, 8'($urandom_range(0, 255)), len, 16'($urandom_range(0, 65535)));
  endtask

  task automatic add_tick();
    int unsigned roll;
    logic [15:0] el;
    roll = $urandom_range(0, 99);
    if (roll < 60) el = 16'($urandom_range(1, 300));
    else if (roll < 85) el = 16'($urandom_range(0, 65535));
    else if (roll < 92) el = 16'd0;
    else el = 16'hFFFF;
    add_beat(OP_TICK, $urandom, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), el);
  endtask

  // hold until every beat is taken and every result is back, then let the block settle
  task automatic wait_idle();
    while (accepted != pushed || pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_MIN_RATE) rate_bps = val;
    else gain_idx = val[2:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned roll, start;
    logic [31:0] rate;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    budget = 0;
    queued_bytes = '0;
    tx_seq = '0;
    rate_bps = '0;
    gain_idx = '0;
    idle_pct = 21;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero rate: budget starts at zero, so queued packets go out and drive it negative
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'd0);
    add_beat(OP_ENQ, 32'h0000_0000, 8'h80, 16'd0, 16'd0);
    add_beat(OP_ENQ, 32'hFFFF_FFFF, 8'h7F, 16'hFFFF, 16'hFFFF);
    add_beat(OP_ENQ, 32'h5A5A_5A5A, 8'hFF, 16'd1, 16'h5A5A);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'hFFFF);
    add_beat(OP_ENQ, 32'hA5A5_A5A5, 8'h00, 16'hFFFF, 16'd0);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'd100);
    wait_idle();

    // full rate, reduced gain: saturated credit, no probing
    write_reg(CFG_MIN_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_GAIN_PHASE, 32'd1);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'hFFFF);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'd1);
    wait_idle();

    // probing phase: leftover budget on an empty queue
    write_reg(CFG_GAIN_PHASE, 32'd0);
    add_beat(OP_ENQ, 32'h1234_5678, 8'h01, 16'd1000, 16'd0);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'd1);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'd0);
    wait_idle();
    write_reg(CFG_MIN_RATE, 32'd1);
    add_beat(OP_TICK, 32'd0, 8'd0, 16'd0, 16'hFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0, 3:    rate = 32'd240000;
        1:       rate = 32'd2000000;
        2:       rate = 32'hFFFF_FFFF;
        4:       rate = 32'd8000;
        5:       rate = 32'd1;
        6:       rate = $urandom;
        default: rate = 32'd0;
      endcase
      write_reg(CFG_MIN_RATE, rate);
      write_reg(CFG_GAIN_PHASE, 32'(ph));
      idle_pct = (ph == 3) ? 0 : 21;
      start = pushed;
      while (pushed - start < PHASE_LEN) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          repeat ($urandom_range(33, 38)) add_packet();
          add_tick();
        end else if (roll < 80) begin
          repeat ($urandom_range(1, 8)) add_packet();
          add_tick();
        end else begin
          add_beat(1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
      end
    end

    wait_idle();
    if (pending_results.size() != 0) mismatches++;
    $display("Ran %0d beats through 8 rate/gain settings: %0d results checked", accepted,
             results_seen);
    $display("  %0d sends, %0d probes, %0d drops, %0d ticks, %0d mismatches", n_sent, n_probe,
             n_drop, n_tick, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
